// ===== hw/rtl/fdss_pkg.sv =====
// Shared types, codes and the segment table of the four-digit display scanner.
package fdss_pkg;

  typedef logic [4:0] glyph_t;
  typedef logic [6:0] seg_t;

  localparam int unsigned NumDigits = 4;

  localparam glyph_t GlyphDash  = 5'd22;
  localparam glyph_t GlyphBlank = 5'd23;

  // Input opcodes; code 3 is not used
  typedef enum logic [1:0] {
    OP_LOAD_NUM  = 2'd0,
    OP_LOAD_DASH = 2'd1,
    OP_TICK      = 2'd2
  } op_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // Word passed from front to back through the queue
  typedef struct packed {
    cmd_e                         kind;
    glyph_t [NumDigits-1:0]       glyphs;
  } cmd_t;

  // Bit0 is segment a, bit6 is g; codes 23 and above are blank
  function automatic seg_t seg_pattern(glyph_t code);
    seg_t pat;
    unique case (code)
      5'd0:    pat = 7'h3F;
      5'd1:    pat = 7'h06;
      5'd2:    pat = 7'h5B;
      5'd3:    pat = 7'h4F;
      5'd4:    pat = 7'h66;
      5'd5:    pat = 7'h6D;
      5'd6:    pat = 7'h7D;
      5'd7:    pat = 7'h07;
      5'd8:    pat = 7'h7F;
      5'd9:    pat = 7'h6F;
      5'd10:   pat = 7'h77;
      5'd11:   pat = 7'h7C;
      5'd12:   pat = 7'h39;
      5'd13:   pat = 7'h5E;
      5'd14:   pat = 7'h79;
      5'd15:   pat = 7'h71;
      5'd16:   pat = 7'h76;
      5'd17:   pat = 7'h38;
      5'd18:   pat = 7'h37;
      5'd19:   pat = 7'h3E;
      5'd20:   pat = 7'h73;
      5'd21:   pat = 7'h5C;
      5'd22:   pat = 7'h40;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/fdss_in_if.sv =====
// Input channel: opcode and value words with valid/ready.
interface fdss_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== hw/rtl/fdss_out_if.sv =====
// Output channel: segment pattern and digit select words with valid/ready.
interface fdss_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] segments;
  logic [3:0] digit_select;

  modport source (output valid, output segments, output digit_select, input ready);
  modport sink   (input valid, input segments, input digit_select, output ready);
endinterface

// ===== hw/rtl/fdss_front.sv =====
// Front end: accepts words, splits numbers into decimal glyphs, pushes commands.
module fdss_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  fdss_in_if.sink          in_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output fdss_pkg::cmd_t   push_data_o
);

  // x / 10 for x below 1029
  function automatic logic [5:0] div10(logic [8:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd205;
    return prod[16:11];
  endfunction

  logic        s1_valid_q;
  logic [1:0]  op_q;
  logic        neg_q;
  logic [8:0]  q100_q;
  logic [6:0]  r100_q;

  logic        neg_d;
  logic [15:0] mag;
  logic [28:0] q100_prod;
  logic [8:0]  q100_d;
  logic [15:0] r100_full;
  logic        keep;

  logic [5:0]  q1000;
  logic [5:0]  q10000;
  logic [3:0]  thousands;
  logic [3:0]  hundreds;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [5:0]  tens_w;
  logic [9:0]  tmp_t;
  logic [9:0]  tmp_h;
  logic [9:0]  tmp_u;

  assign in_i.ready = !s1_valid_q || push_ready_i;

  // Stage 1: magnitude, then split into mag / 100 and mag % 100
  assign neg_d     = in_i.value[15];
  assign mag       = neg_d ? 16'(-in_i.value) : in_i.value;
  assign q100_prod = 29'(mag) * 29'd5243;
  assign q100_d    = q100_prod[27:19];
  assign r100_full = mag - 16'(q100_d) * 16'd100;
  assign keep      = (in_i.op == fdss_pkg::OP_LOAD_NUM) ||
                     (in_i.op == fdss_pkg::OP_LOAD_DASH) ||
                     (in_i.op == fdss_pkg::OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      op_q   <= in_i.op;
      neg_q  <= neg_d;
      q100_q <= q100_d;
      r100_q <= r100_full[6:0];
    end
  end

  // Stage 2: narrow digit split
  always_comb begin
    q1000     = div10(q100_q);
    q10000    = div10(9'(q1000));
    tmp_t     = 10'(q1000) - 10'(q10000) * 10'd10;
    thousands = tmp_t[3:0];
    tmp_h     = 10'(q100_q) - 10'(q1000) * 10'd10;
    hundreds  = tmp_h[3:0];
    tens_w    = div10(9'(r100_q));
    tens      = tens_w[3:0];
    tmp_u     = 10'(r100_q) - 10'(tens_w) * 10'd10;
    units     = tmp_u[3:0];
  end

  always_comb begin
    push_valid_o = s1_valid_q;
    push_data_o.kind = (op_q == fdss_pkg::OP_TICK) ? fdss_pkg::CMD_TICK
                                                   : fdss_pkg::CMD_LOAD;
    if (op_q == fdss_pkg::OP_LOAD_NUM) begin
      push_data_o.glyphs[0] = neg_q ? fdss_pkg::GlyphDash : 5'(thousands);
      push_data_o.glyphs[1] = 5'(hundreds);
      push_data_o.glyphs[2] = 5'(tens);
      push_data_o.glyphs[3] = 5'(units);
    end else begin
      push_data_o.glyphs = {fdss_pkg::NumDigits{fdss_pkg::GlyphDash}};
    end
  end

endmodule

// ===== hw/rtl/fdss_queue.sv =====
// Two-word queue between front and back.
module fdss_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  fdss_pkg::cmd_t   push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output fdss_pkg::cmd_t   pop_data_o
);

  fdss_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/fdss_back.sv =====
// Back end: holds the glyph buffer and scan position, drives the output register.
module fdss_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_pop_o,
  input  fdss_pkg::cmd_t   cmd_i,
  fdss_out_if.source       out_o
);

  fdss_pkg::glyph_t [fdss_pkg::NumDigits-1:0] glyph_q;
  logic [1:0] scan_q;
  logic       out_valid_q;
  logic [6:0] seg_q;
  logic [3:0] sel_q;
  logic       is_tick;

  assign is_tick   = (cmd_i.kind == fdss_pkg::CMD_TICK);
  // loads never wait on the output side
  assign cmd_pop_o = cmd_valid_i && (!is_tick || !out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_q     <= '0;
      scan_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o && !is_tick) begin
        glyph_q <= cmd_i.glyphs;
      end
      if (cmd_pop_o && is_tick) begin
        scan_q      <= scan_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_tick) begin
      seg_q <= fdss_pkg::seg_pattern(glyph_q[scan_q]);
      sel_q <= ~(4'b0001 << scan_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = seg_q;
  assign out_o.digit_select = sel_q;

endmodule

// ===== hw/rtl/four_digit_seven_segment_scan.sv =====
// Four-digit multiplexed seven-segment scanner: one word per clock in, a scan
// result one word per tick out. A word is taken every cycle while the two-word
// queue has room; a load-number word spends one register stage in the front end
// for its decimal split, crosses the queue and updates the glyph buffer in the
// back end, and a scan tick passes the front-end register and the queue before
// it loads the output register, from which the receiver takes its segments.
// Ticks wait only on the output register; loads and unused opcodes never
// produce an output word. After reset the display reads 0000 and scanning
// starts at the leftmost digit.
module four_digit_seven_segment_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdss_in_if.sink     in_i,
  fdss_out_if.source  out_o
);

  logic           push_valid;
  logic           push_ready;
  fdss_pkg::cmd_t push_data;
  logic           cmd_valid;
  logic           cmd_pop;
  fdss_pkg::cmd_t cmd_data;

  fdss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fdss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (cmd_valid),
    .pop_i        (cmd_pop),
    .pop_data_o   (cmd_data)
  );

  fdss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_data),
    .out_o       (out_o)
  );

endmodule
